@@ hw/rtl/forth_stack_machine_step_defines.svh @@
// assertion macros for the forth stack machine step block
`ifndef FORTH_STACK_MACHINE_STEP_DEFINES_SVH
`define FORTH_STACK_MACHINE_STEP_DEFINES_SVH

// implication checked at the same clock edge
`define FSMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsms assertion failed");

// implication checked at the following clock edge
`define FSMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsms assertion failed");

`endif

@@ hw/rtl/fsms_pkg.sv @@
// package with token codes, status codes and default sizes of the forth step block
`default_nettype none

package fsms_pkg;

  localparam int unsigned DEF_DATA_DEPTH   = 32;
  localparam int unsigned DEF_RETURN_DEPTH = 32;

  localparam logic [7:0] OP_LIT    = 8'h09;
  localparam logic [7:0] OP_DUP    = 8'h0A;
  localparam logic [7:0] OP_DROP   = 8'h0B;
  localparam logic [7:0] OP_ADD    = 8'h0C;
  localparam logic [7:0] OP_SUB    = 8'h0D;
  localparam logic [7:0] OP_INC    = 8'h0E;
  localparam logic [7:0] OP_DEC    = 8'h0F;
  localparam logic [7:0] OP_SWAP   = 8'h10;
  localparam logic [7:0] OP_BRANCH = 8'h11;
  localparam logic [7:0] OP_EXIT   = 8'h7F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ILLEGAL  = 3'd1,
    ST_DUNDER   = 3'd2,
    ST_DOVER    = 3'd3,
    ST_RUNDER   = 3'd4,
    ST_ROVER    = 3'd5
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/fsms_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module fsms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/forth_stack_machine_step.sv @@
// top level of the forth stack machine step block
// Executes one token of a 16-bit token-threaded Forth machine per transaction and
// returns one result per transaction. A new token is accepted in every cycle; the
// result sits in the output register from the cycle after acceptance, and the input
// keeps accepting while that result waits to be taken as long as the output side
// drains it in the same cycle. The rate is set by the loop from the IP, top of stack,
// cached second cell and cached top return address back to themselves. Both stacks
// live in registered-read RAMs; the entry below the cached one is read ahead each
// cycle, so a pop finds it ready. No clearing pass after reset is needed.
`default_nettype none

module forth_stack_machine_step #(
  parameter int unsigned DATA_DEPTH   = fsms_pkg::DEF_DATA_DEPTH,
  parameter int unsigned RETURN_DEPTH = fsms_pkg::DEF_RETURN_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // opcode[7:0], operand[23:8]
  input  wire logic [0:0]  s_tuser,   // mode[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // next_address[15:0], top_of_stack[31:16], data_depth[37:32],
  // return_depth[43:38], status[46:44], zero[47]
  output logic      [47:0] m_tdata
);

  import fsms_pkg::*;

  localparam int unsigned DAW = $clog2(DATA_DEPTH);
  localparam int unsigned DCW = $clog2(DATA_DEPTH + 1);
  localparam int unsigned RAW = $clog2(RETURN_DEPTH);
  localparam int unsigned RCW = $clog2(RETURN_DEPTH + 1);

  logic        mode;
  logic [7:0]  opcode;
  logic [15:0] operand;
  logic        s_fire;

  logic [15:0]    instr_pointer, instr_pointer_next;
  logic [15:0]    top_cell, top_cell_next;
  logic [15:0]    second_cell, second_cell_next;
  logic [DCW-1:0] data_count, data_count_next;
  logic [15:0]    return_top, return_top_next;
  logic [RCW-1:0] return_count, return_count_next;
  status_t        status;

  logic           d_we;
  logic [DAW-1:0] d_waddr;
  logic [DAW-1:0] d_raddr;
  logic [15:0]    d_rdata;
  logic [DCW-1:0] d_count_eff;
  logic [DCW-1:0] d_below;

  logic           r_we;
  logic [RAW-1:0] r_waddr;
  logic [RAW-1:0] r_raddr;
  logic [15:0]    r_rdata;
  logic [RCW-1:0] r_count_eff;
  logic [RCW-1:0] r_below;

  assign mode     = s_tuser[0];
  assign opcode   = s_tdata[7:0];
  assign operand  = s_tdata[23:8];
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    instr_pointer_next = instr_pointer;
    top_cell_next      = top_cell;
    second_cell_next   = second_cell;
    data_count_next    = data_count;
    return_top_next    = return_top;
    return_count_next  = return_count;
    status             = ST_OK;
    d_we               = 1'b0;
    d_waddr            = data_count[DAW-1:0];
    r_we               = 1'b0;
    r_waddr            = return_count[RAW-1:0];
    if (mode) begin
      instr_pointer_next = operand;
      top_cell_next      = 16'd0;
      data_count_next    = '0;
      return_count_next  = '0;
    end else if (opcode[7]) begin
      if (return_count >= RCW'(RETURN_DEPTH)) begin
        status = ST_ROVER;
      end else begin
        r_we               = 1'b1;
        return_top_next    = instr_pointer + 16'd2;
        return_count_next  = return_count + RCW'(1);
        instr_pointer_next = instr_pointer + 16'd4 + {opcode, operand[7:0]};
      end
    end else begin
      unique case (opcode) inside
        OP_LIT, OP_DUP: begin
          if (data_count >= DCW'(DATA_DEPTH)) begin
            status = ST_DOVER;
          end else begin
            d_we             = 1'b1;
            second_cell_next = top_cell;
            data_count_next  = data_count + DCW'(1);
            if (opcode == OP_LIT) begin
              top_cell_next      = operand;
              instr_pointer_next = instr_pointer + 16'd3;
            end else begin
              instr_pointer_next = instr_pointer + 16'd1;
            end
          end
        end
        OP_DROP, OP_ADD, OP_SUB: begin
          if (data_count == '0) begin
            status = ST_DUNDER;
          end else begin
            second_cell_next   = d_rdata;
            data_count_next    = data_count - DCW'(1);
            instr_pointer_next = instr_pointer + 16'd1;
            if (opcode == OP_DROP) begin
              top_cell_next = second_cell;
            end else if (opcode == OP_ADD) begin
              top_cell_next = second_cell + top_cell;
            end else begin
              top_cell_next = second_cell - top_cell;
            end
          end
        end
        OP_INC: begin
          top_cell_next      = top_cell + 16'd1;
          instr_pointer_next = instr_pointer + 16'd1;
        end
        OP_DEC: begin
          top_cell_next      = top_cell - 16'd1;
          instr_pointer_next = instr_pointer + 16'd1;
        end
        OP_SWAP: begin
          if (data_count == '0) begin
            status = ST_DUNDER;
          end else begin
            d_we               = 1'b1;
            d_waddr            = DAW'(data_count - DCW'(1));
            second_cell_next   = top_cell;
            top_cell_next      = second_cell;
            instr_pointer_next = instr_pointer + 16'd1;
          end
        end
        OP_BRANCH: begin
          instr_pointer_next = instr_pointer + 16'd1 - {8'd0, operand[7:0]};
        end
        OP_EXIT: begin
          if (return_count == '0) begin
            status = ST_RUNDER;
          end else begin
            return_count_next  = return_count - RCW'(1);
            instr_pointer_next = return_top;
            return_top_next    = r_rdata;
          end
        end
        default: begin
          status = ST_ILLEGAL;
        end
      endcase
    end
  end

  // read ahead the entry two below the new count so that a pop finds it ready
  assign d_count_eff = s_fire ? data_count_next : data_count;
  assign d_below     = d_count_eff - DCW'(2);
  assign d_raddr     = d_below[DAW-1:0];
  assign r_count_eff = s_fire ? return_count_next : return_count;
  assign r_below     = r_count_eff - RCW'(2);
  assign r_raddr     = r_below[RAW-1:0];

  fsms_ram #(
    .WIDTH (16),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (s_fire && d_we),
    .waddr (d_waddr),
    .wdata (top_cell),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  fsms_ram #(
    .WIDTH (16),
    .DEPTH (RETURN_DEPTH)
  ) u_return_ram (
    .clk   (clk),
    .we    (s_fire && r_we),
    .waddr (r_waddr),
    .wdata (return_top_next),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      instr_pointer <= 16'd0;
      top_cell      <= 16'd0;
      data_count    <= '0;
      return_count  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s_fire) begin
        instr_pointer <= instr_pointer_next;
        top_cell      <= top_cell_next;
        data_count    <= data_count_next;
        return_count  <= return_count_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      second_cell <= second_cell_next;
      return_top  <= return_top_next;
      m_tdata     <= {1'b0, status, 6'(return_count_next), 6'(data_count_next),
                      top_cell_next, instr_pointer_next};
    end
  end

  `include "forth_stack_machine_step_defines.svh"

  `FSMS_ASSERT_NOW(a_data_count_range, 1'b1, data_count <= DCW'(DATA_DEPTH))
  `FSMS_ASSERT_NOW(a_return_count_range, 1'b1, return_count <= RCW'(RETURN_DEPTH))
  `FSMS_ASSERT_NEXT(a_fault_holds_state, s_fire && status != ST_OK,
    instr_pointer == $past(instr_pointer) && data_count == $past(data_count) &&
    return_count == $past(return_count) && top_cell == $past(top_cell))
  `FSMS_ASSERT_NEXT(a_restart_clears, s_fire && mode,
    data_count == '0 && return_count == '0 && top_cell == 16'd0)
  `FSMS_ASSERT_NEXT(a_result_matches_state, s_fire,
    m_tvalid && m_tdata[15:0] == instr_pointer && m_tdata[31:16] == top_cell)

endmodule

`default_nettype wire
